FILE: rtl/core/tddr_pkg.sv
// ============================================================================
// tddr_pkg
// Shared constants and types of the thick DDA line rasterizer: display size,
// brush limit, status codes and the divider request/response bundles.
// ============================================================================
`default_nettype none

package tddr_pkg;

    localparam int DISPLAY_WIDTH  = 320;
    localparam int DISPLAY_HEIGHT = 240;
    localparam int MAX_WEIGHT     = 8;

    // Q16 rounding divide: quotient bits produced per division
    localparam int DIV_BITS   = 17;
    localparam int DIV_CNT_W  = 5;
    localparam int COORD_W    = 11;
    localparam int MAG_W      = 10;
    localparam int ACC_W      = 27;
    localparam int INC_W      = 18;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_LOAD = 2'd1;
    localparam logic [1:0] STATUS_NO_LINE  = 2'd2;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] mag;
        logic [MAG_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic                done;
        logic [DIV_BITS-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

FILE: rtl/core/thick_dda_line_rasterizer.sv
// ============================================================================
// thick_dda_line_rasterizer
// DDA line rasterizer with a diamond brush in Q16 fixed point.
// Load requests set up the line through a shared iterative divider; step
// requests walk the brush of the current DDA point and emit its pixels.
// ============================================================================
// Load: after accept, two 17-bit divisions run one after the other on the one
//   shared divider (x, then y) before the status result is sent.
// Step: the brush cells of the current point are scanned, then the last pixel
//   is flushed; one candidate cell is scanned per cycle while the output is free.
// Invalid loads and steps without a line answer straight from the response state.
// One request at a time: s_tready is high only while the sequencer is idle.
// Reset is synchronous, active low; it clears the line state (no line active).
// ============================================================================
`default_nettype none

module thick_dda_line_rasterizer (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // request stream
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    // tdata: x_start[10:0], y_start[21:11], x_end[32:22], y_end[43:33],
    //        pen_color[51:44], pen_weight[55:52]
    input  wire  [55:0] i_s_tdata,
    // tuser: req_type[0]
    input  wire  [0:0]  i_s_tuser,
    // result stream
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    // tdata: pixel_x[8:0], pixel_y[16:9], pixel_color[24:17], line_done[25],
    //        zero[31:26]
    output logic [31:0] o_m_tdata,
    // tuser: pixel_valid[0], status[2:1]
    output logic [2:0]  o_m_tuser,
    output logic        o_m_tlast
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIVX,
        S_DIVY,
        S_RESP,
        S_SCAN,
        S_FLUSH
    } t_state;

    localparam int CW = tddr_pkg::COORD_W;

    // ---------------- registers ----------------
    t_state r_state, n_state;

    // line state
    logic signed [tddr_pkg::ACC_W-1:0] r_xacc, n_xacc, r_yacc, n_yacc;
    logic [tddr_pkg::INC_W-1:0]        r_xinc, n_xinc, r_yinc, n_yinc;
    logic [9:0]                        r_steps_left, n_steps_left;
    logic [7:0]                        r_color, n_color;
    logic [2:0]                        r_half, n_half;
    logic                              r_odd, n_odd;
    logic                              r_active, n_active;

    // captured load request
    logic signed [CW-1:0] r_x1, n_x1, r_y1, n_y1, r_x2, n_x2, r_y2, n_y2;
    logic [7:0]           r_pcol, n_pcol;
    logic [3:0]           r_pw, n_pw;
    logic [tddr_pkg::DIV_BITS-1:0] r_qx, n_qx;
    logic [1:0]           r_rsp_status, n_rsp_status;

    // brush walk
    logic signed [CW-1:0] r_cx, n_cx, r_cy, n_cy;
    logic signed [4:0]    r_yw, n_yw, r_xw, n_xw;
    logic                 r_sdone, n_sdone;
    // one pixel held back so the last one can be flagged
    logic                 r_pd_v, n_pd_v;
    logic [8:0]           r_pd_x, n_pd_x;
    logic [7:0]           r_pd_y, n_pd_y;

    // output register
    logic       r_o_valid, n_o_valid;
    logic [8:0] r_o_px, n_o_px;
    logic [7:0] r_o_py, n_o_py;
    logic [7:0] r_o_col, n_o_col;
    logic       r_o_pv, n_o_pv;
    logic       r_o_last, n_o_last;
    logic       r_o_done, n_o_done;
    logic [1:0] r_o_status, n_o_status;

    // ---------------- shared divider ----------------
    tddr_pkg::t_div_req div_req;
    tddr_pkg::t_div_rsp div_rsp;

    tddr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ---------------- helpers ----------------
    // first column offset of brush row yw
    function automatic logic signed [4:0] row_start(input logic signed [4:0] yw,
                                                    input logic [2:0] h,
                                                    input logic odd);
        logic signed [4:0] ay;
        ay = yw[4] ? -yw : yw;
        return ay - $signed({2'b00, h}) + $signed({4'b0000, odd});
    endfunction

    // signed Q16 increment from magnitude quotient
    function automatic logic [tddr_pkg::INC_W-1:0] apply_sign(
            input logic neg, input logic [tddr_pkg::DIV_BITS-1:0] q);
        logic [tddr_pkg::INC_W-1:0] qe;
        qe = {1'b0, q};
        return neg ? (~qe + 18'd1) : qe;
    endfunction

    // Q16 accumulator truncated toward zero
    function automatic logic signed [CW-1:0] trunc_q16(
            input logic signed [tddr_pkg::ACC_W-1:0] a);
        logic round_up;
        round_up = a[tddr_pkg::ACC_W-1] && (a[15:0] != 16'd0);
        return $signed(a[tddr_pkg::ACC_W-1:16] + {10'd0, round_up});
    endfunction

    // ---------------- request decode ----------------
    logic                 in_acc, out_free;
    logic signed [CW-1:0] s_x1, s_y1, s_x2, s_y2;
    logic [3:0]           s_w;
    logic                 ld_ok;

    assign s_x1 = $signed(i_s_tdata[10:0]);
    assign s_y1 = $signed(i_s_tdata[21:11]);
    assign s_x2 = $signed(i_s_tdata[32:22]);
    assign s_y2 = $signed(i_s_tdata[43:33]);
    assign s_w  = i_s_tdata[55:52];

    assign ld_ok = !s_x1[CW-1] && ({1'b0, s_x1} < 12'(tddr_pkg::DISPLAY_WIDTH))  &&
                   !s_x2[CW-1] && ({1'b0, s_x2} < 12'(tddr_pkg::DISPLAY_WIDTH))  &&
                   !s_y1[CW-1] && ({1'b0, s_y1} < 12'(tddr_pkg::DISPLAY_HEIGHT)) &&
                   !s_y2[CW-1] && ({1'b0, s_y2} < 12'(tddr_pkg::DISPLAY_HEIGHT)) &&
                   (s_w != 4'd0) && (s_w <= 4'(tddr_pkg::MAX_WEIGHT));

    assign o_s_tready = (r_state == S_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_o_valid || i_m_tready;

    // ---------------- line setup arithmetic ----------------
    logic signed [CW:0]        dx, dy;
    logic [CW:0]               adx_f, ady_f;
    logic [tddr_pkg::MAG_W-1:0] adx, ady, steps_raw, steps;

    assign dx        = {r_x2[CW-1], r_x2} - {r_x1[CW-1], r_x1};
    assign dy        = {r_y2[CW-1], r_y2} - {r_y1[CW-1], r_y1};
    assign adx_f     = dx[CW] ? -dx : dx;
    assign ady_f     = dy[CW] ? -dy : dy;
    // endpoints on the display keep |d| within 10 bits
    assign adx       = adx_f[tddr_pkg::MAG_W-1:0];
    assign ady       = ady_f[tddr_pkg::MAG_W-1:0];
    assign steps_raw = (adx > ady) ? adx : ady;
    assign steps     = (steps_raw == '0) ? 10'd1 : steps_raw;

    assign div_req.start = (r_state == S_PREP) || ((r_state == S_DIVX) && div_rsp.done);
    assign div_req.mag   = (r_state == S_PREP) ? adx : ady;
    assign div_req.steps = steps;

    // ---------------- brush candidate ----------------
    logic signed [4:0]  hs, ayw, row_end, yw_next;
    logic               in_row;
    logic signed [CW:0] ox, oy;
    logic               on_disp;

    assign hs      = $signed({2'b00, r_half});
    assign ayw     = r_yw[4] ? -r_yw : r_yw;
    assign row_end = hs - ayw - 5'sd1;
    assign in_row  = (r_xw <= row_end);
    assign yw_next = r_yw + 5'sd1;

    assign ox = {r_cx[CW-1], r_cx} + {{(CW-4){r_xw[4]}}, r_xw};
    assign oy = {r_cy[CW-1], r_cy} + {{(CW-4){r_yw[4]}}, r_yw};
    assign on_disp = !ox[CW] && (ox < 12'sd0 + $signed(12'(tddr_pkg::DISPLAY_WIDTH))) &&
                     !oy[CW] && (oy < 12'sd0 + $signed(12'(tddr_pkg::DISPLAY_HEIGHT)));

    // ---------------- sequencer ----------------
    always_comb begin
        n_state      = r_state;
        n_xacc       = r_xacc;
        n_yacc       = r_yacc;
        n_xinc       = r_xinc;
        n_yinc       = r_yinc;
        n_steps_left = r_steps_left;
        n_color      = r_color;
        n_half       = r_half;
        n_odd        = r_odd;
        n_active     = r_active;
        n_x1         = r_x1;
        n_y1         = r_y1;
        n_x2         = r_x2;
        n_y2         = r_y2;
        n_pcol       = r_pcol;
        n_pw         = r_pw;
        n_qx         = r_qx;
        n_rsp_status = r_rsp_status;
        n_cx         = r_cx;
        n_cy         = r_cy;
        n_yw         = r_yw;
        n_xw         = r_xw;
        n_sdone      = r_sdone;
        n_pd_v       = r_pd_v;
        n_pd_x       = r_pd_x;
        n_pd_y       = r_pd_y;
        n_o_valid    = r_o_valid;
        n_o_px       = r_o_px;
        n_o_py       = r_o_py;
        n_o_col      = r_o_col;
        n_o_pv       = r_o_pv;
        n_o_last     = r_o_last;
        n_o_done     = r_o_done;
        n_o_status   = r_o_status;

        if (r_o_valid && i_m_tready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (!i_s_tuser[0]) begin
                        if (ld_ok) begin
                            n_x1    = s_x1;
                            n_y1    = s_y1;
                            n_x2    = s_x2;
                            n_y2    = s_y2;
                            n_pcol  = i_s_tdata[51:44];
                            n_pw    = s_w;
                            n_state = S_PREP;
                        end else begin
                            n_rsp_status = tddr_pkg::STATUS_BAD_LOAD;
                            n_state      = S_RESP;
                        end
                    end else if (!r_active) begin
                        n_rsp_status = tddr_pkg::STATUS_NO_LINE;
                        n_state      = S_RESP;
                    end else begin
                        n_cx    = trunc_q16(r_xacc);
                        n_cy    = trunc_q16(r_yacc);
                        n_sdone = (r_steps_left == 10'd0);
                        n_yw    = -hs;
                        n_xw    = row_start(-hs, r_half, r_odd);
                        n_pd_v  = 1'b0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_PREP: begin
                // divider for x starts this cycle
                n_state = S_DIVX;
            end
            S_DIVX: begin
                if (div_rsp.done) begin
                    n_qx    = div_rsp.quot;
                    n_state = S_DIVY;
                end
            end
            S_DIVY: begin
                if (div_rsp.done) begin
                    n_xinc       = apply_sign(dx[CW], r_qx);
                    n_yinc       = apply_sign(dy[CW], div_rsp.quot);
                    n_xacc       = {r_x1, 16'd0};
                    n_yacc       = {r_y1, 16'd0};
                    n_steps_left = steps;
                    n_color      = r_pcol;
                    n_odd        = r_pw[0];
                    n_half       = 3'(({1'b0, r_pw} + {4'd0, r_pw[0]}) >> 1);
                    n_active     = 1'b1;
                    n_rsp_status = tddr_pkg::STATUS_OK;
                    n_state      = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_px     = '0;
                    n_o_py     = '0;
                    n_o_col    = '0;
                    n_o_pv     = 1'b0;
                    n_o_last   = 1'b1;
                    n_o_done   = 1'b0;
                    n_o_status = r_rsp_status;
                    n_state    = S_IDLE;
                end
            end
            S_SCAN: begin
                if (in_row) begin
                    if (on_disp) begin
                        if (!r_pd_v) begin
                            n_pd_v = 1'b1;
                            n_pd_x = ox[8:0];
                            n_pd_y = oy[7:0];
                            n_xw   = r_xw + 5'sd1;
                        end else if (out_free) begin
                            n_o_valid  = 1'b1;
                            n_o_px     = r_pd_x;
                            n_o_py     = r_pd_y;
                            n_o_col    = r_color;
                            n_o_pv     = 1'b1;
                            n_o_last   = 1'b0;
                            n_o_done   = r_sdone;
                            n_o_status = tddr_pkg::STATUS_OK;
                            n_pd_x     = ox[8:0];
                            n_pd_y     = oy[7:0];
                            n_xw       = r_xw + 5'sd1;
                        end
                    end else begin
                        n_xw = r_xw + 5'sd1;
                    end
                end else if (yw_next == hs) begin
                    n_state = S_FLUSH;
                end else begin
                    n_yw = yw_next;
                    n_xw = row_start(yw_next, r_half, r_odd);
                end
            end
            S_FLUSH: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_px     = r_pd_v ? r_pd_x : 9'd0;
                    n_o_py     = r_pd_v ? r_pd_y : 8'd0;
                    n_o_col    = r_pd_v ? r_color : 8'd0;
                    n_o_pv     = r_pd_v;
                    n_o_last   = 1'b1;
                    n_o_done   = r_sdone;
                    n_o_status = tddr_pkg::STATUS_OK;
                    n_pd_v     = 1'b0;
                    n_xacc     = r_xacc + {{9{r_xinc[tddr_pkg::INC_W-1]}}, r_xinc};
                    n_yacc     = r_yacc + {{9{r_yinc[tddr_pkg::INC_W-1]}}, r_yinc};
                    if (r_sdone) begin
                        n_active = 1'b0;
                    end else begin
                        n_steps_left = r_steps_left - 10'd1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_xacc       <= '0;
            r_yacc       <= '0;
            r_xinc       <= '0;
            r_yinc       <= '0;
            r_steps_left <= '0;
            r_color      <= '0;
            r_half       <= '0;
            r_odd        <= 1'b0;
            r_active     <= 1'b0;
            r_x1         <= '0;
            r_y1         <= '0;
            r_x2         <= '0;
            r_y2         <= '0;
            r_pcol       <= '0;
            r_pw         <= '0;
            r_qx         <= '0;
            r_rsp_status <= tddr_pkg::STATUS_OK;
            r_cx         <= '0;
            r_cy         <= '0;
            r_yw         <= '0;
            r_xw         <= '0;
            r_sdone      <= 1'b0;
            r_pd_v       <= 1'b0;
            r_pd_x       <= '0;
            r_pd_y       <= '0;
            r_o_valid    <= 1'b0;
            r_o_px       <= '0;
            r_o_py       <= '0;
            r_o_col      <= '0;
            r_o_pv       <= 1'b0;
            r_o_last     <= 1'b0;
            r_o_done     <= 1'b0;
            r_o_status   <= tddr_pkg::STATUS_OK;
        end else begin
            r_state      <= n_state;
            r_xacc       <= n_xacc;
            r_yacc       <= n_yacc;
            r_xinc       <= n_xinc;
            r_yinc       <= n_yinc;
            r_steps_left <= n_steps_left;
            r_color      <= n_color;
            r_half       <= n_half;
            r_odd        <= n_odd;
            r_active     <= n_active;
            r_x1         <= n_x1;
            r_y1         <= n_y1;
            r_x2         <= n_x2;
            r_y2         <= n_y2;
            r_pcol       <= n_pcol;
            r_pw         <= n_pw;
            r_qx         <= n_qx;
            r_rsp_status <= n_rsp_status;
            r_cx         <= n_cx;
            r_cy         <= n_cy;
            r_yw         <= n_yw;
            r_xw         <= n_xw;
            r_sdone      <= n_sdone;
            r_pd_v       <= n_pd_v;
            r_pd_x       <= n_pd_x;
            r_pd_y       <= n_pd_y;
            r_o_valid    <= n_o_valid;
            r_o_px       <= n_o_px;
            r_o_py       <= n_o_py;
            r_o_col      <= n_o_col;
            r_o_pv       <= n_o_pv;
            r_o_last     <= n_o_last;
            r_o_done     <= n_o_done;
            r_o_status   <= n_o_status;
        end
    end

    // ---------------- outputs ----------------
    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {6'd0, r_o_done, r_o_col, r_o_py, r_o_px};
    assign o_m_tuser  = {r_o_status, r_o_pv};
    assign o_m_tlast  = r_o_last;

`ifndef SYNTHESIS
    // held-back pixel only exists while a stamp is being walked
    a_pend_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pd_v |-> (r_state == S_SCAN || r_state == S_FLUSH))
        else $error("pending pixel outside brush walk");

    // divider completion only expected during line setup
    a_div_done_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIVX || r_state == S_DIVY))
        else $error("divider done outside setup");

    // a result without a pixel closes its request
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser[0]) |-> o_m_tlast)
        else $error("empty result not marked last");

    // error status never carries a pixel
    a_err_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser[2:1] != tddr_pkg::STATUS_OK)) |-> !o_m_tuser[0])
        else $error("pixel with error status");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_s_tready)
        else $error("ready right after accept");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/tddr_div.sv
// ============================================================================
// tddr_div
// Restoring divider, one quotient bit per cycle:
// quot = (mag * 2^17 + steps) / (2 * steps), for mag <= steps.
// ============================================================================
`default_nettype none

module tddr_div (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  tddr_pkg::t_div_req i_req,
    output tddr_pkg::t_div_rsp o_rsp
);

    logic [tddr_pkg::MAG_W:0]        r_rem;
    logic [tddr_pkg::DIV_BITS-1:0]   r_num;
    logic [tddr_pkg::DIV_BITS-1:0]   r_quot;
    logic [tddr_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic                            r_done;

    logic [tddr_pkg::MAG_W:0]   divisor;
    logic [tddr_pkg::MAG_W+1:0] trial;
    logic                       ge;

    // divisor is 2*steps; remainder stays below it
    assign divisor = {i_req.steps, 1'b0};
    assign trial   = {r_rem, r_num[tddr_pkg::DIV_BITS-1]};
    assign ge      = trial >= {1'b0, divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= '0;
            r_num  <= '0;
            r_quot <= '0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                // numerator top bits are mag, low 17 bits are the rounding term
                r_rem  <= {1'b0, i_req.mag};
                r_num  <= tddr_pkg::DIV_BITS'(i_req.steps);
                r_quot <= '0;
                r_cnt  <= tddr_pkg::DIV_CNT_W'(tddr_pkg::DIV_BITS);
            end else if (r_cnt != '0) begin
                r_rem  <= ge ? tddr_pkg::MAG_W'(trial - {1'b0, divisor}) + 11'd0
                             : trial[tddr_pkg::MAG_W:0];
                r_num  <= {r_num[tddr_pkg::DIV_BITS-2:0], 1'b0};
                r_quot <= {r_quot[tddr_pkg::DIV_BITS-2:0], ge};
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == tddr_pkg::DIV_CNT_W'(1));
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

`default_nettype wire
